// ===== rtl/swm_pkg.sv =====
// Shared types, character codes and character-class functions of the whitespace minifier.
package swm_pkg;

  typedef enum logic [1:0] {
    SCAN_NORMAL    = 2'd0,
    SCAN_STRING    = 2'd1,
    SCAN_LITERAL   = 2'd2,
    SCAN_DIRECTIVE = 2'd3
  } scan_mode_t;

  // literal progress codes
  localparam logic [1:0] LIT_IDLE    = 2'd0;
  localparam logic [1:0] LIT_CLOSE   = 2'd1;
  localparam logic [1:0] LIT_ESCAPED = 2'd2;
  localparam logic [1:0] LIT_FIRST   = 2'd3;

  // newline_mode values
  localparam logic MODE_LINE  = 1'b0;
  localparam logic MODE_WHOLE = 1'b1;

  // command values
  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_END  = 1'b1;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef struct packed {
    scan_mode_t  scan_mode;
    logic [1:0]  literal_left;
    logic [7:0]  last_emitted;
    logic        pending_white;
    logic        line_started;
  } swm_state_t;

  typedef struct packed {
    logic [1:0] count;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
  } swm_result_t;

  localparam swm_state_t STATE_RESET = '{
    scan_mode:     SCAN_NORMAL,
    literal_left:  LIT_IDLE,
    last_emitted:  CH_NUL,
    pending_white: 1'b0,
    line_started:  1'b0
  };

  function automatic logic is_white(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_LBRACE) ||
           (c == CH_RBRACE) || (c == CH_LBRACK) || (c == CH_RBRACK) ||
           (c == CH_LT) || (c == CH_GT) || (c == CH_PLUS) || (c == CH_MINUS) ||
           (c == CH_SLASH) || (c == CH_STAR) || (c == CH_AMP) || (c == CH_CARET) ||
           (c == CH_PCT) || (c == CH_SEMI) || (c == CH_COLON) || (c == CH_EQ) ||
           (c == CH_COMMA) || (c == CH_NUL);
  endfunction

  function automatic logic eq_meets_op(input logic [7:0] a, input logic [7:0] b);
    return (a == CH_EQ) && ((b == CH_PLUS) || (b == CH_MINUS) || (b == CH_STAR) ||
                            (b == CH_SLASH) || (b == CH_LT) || (b == CH_GT));
  endfunction

  function automatic logic space_needed(input logic [7:0] a, input logic [7:0] b);
    logic plain;
    plain = !((a == CH_LF) || (b == CH_LF)) && !is_punct(a) && !is_punct(b);
    return plain || eq_meets_op(a, b) || eq_meets_op(b, a);
  endfunction

endpackage

// ===== rtl/swm_step.sv =====
// Next-state and output bytes of the minifier for one request.
module swm_step (
  input  logic                newline_mode,
  input  logic                command,
  input  logic [7:0]          in_byte,
  input  swm_pkg::swm_state_t state_cur,
  output swm_pkg::swm_state_t state_next,
  output swm_pkg::swm_result_t result
);

  // in-line compaction shared by line mode and directive lines
  swm_pkg::swm_state_t lb_state;
  swm_pkg::swm_result_t lb_result;

  always_comb begin
    lb_state  = state_cur;
    lb_result = '{count: 2'd0, first_byte: in_byte, second_byte: in_byte};
    if (swm_pkg::is_white(in_byte)) begin
      if (state_cur.line_started) lb_state.pending_white = 1'b1;
    end else begin
      if (state_cur.line_started && state_cur.pending_white &&
          swm_pkg::space_needed(state_cur.last_emitted, in_byte)) begin
        lb_result.count      = 2'd2;
        lb_result.first_byte = swm_pkg::CH_SPACE;
      end else begin
        lb_result.count = 2'd1;
      end
      lb_state.line_started  = 1'b1;
      lb_state.pending_white = 1'b0;
      lb_state.last_emitted  = in_byte;
    end
  end

  always_comb begin
    state_next = state_cur;
    result     = '{count: 2'd0, first_byte: in_byte, second_byte: in_byte};
    if (command == swm_pkg::CMD_END) begin
      if (newline_mode == swm_pkg::MODE_LINE) begin
        if (state_cur.line_started) result.count = 2'd1;
      end else if (state_cur.scan_mode == swm_pkg::SCAN_DIRECTIVE) begin
        result.count = 2'd1;
      end
      result.first_byte = swm_pkg::CH_LF;
      state_next = swm_pkg::STATE_RESET;
    end else if (newline_mode == swm_pkg::MODE_LINE) begin
      if (in_byte == swm_pkg::CH_LF) begin
        if (state_cur.line_started) result.count = 2'd1;
        state_next.line_started  = 1'b0;
        state_next.pending_white = 1'b0;
      end else begin
        state_next = lb_state;
        result     = lb_result;
      end
    end else if (state_cur.scan_mode == swm_pkg::SCAN_LITERAL) begin
      // copy literal bytes untouched; spacing state is left alone
      result.count = 2'd1;
      priority if (state_cur.literal_left == swm_pkg::LIT_FIRST) begin
        state_next.literal_left = (in_byte == swm_pkg::CH_BSLASH) ?
                                  swm_pkg::LIT_ESCAPED : swm_pkg::LIT_CLOSE;
      end else if (state_cur.literal_left == swm_pkg::LIT_ESCAPED) begin
        state_next.literal_left = swm_pkg::LIT_CLOSE;
      end else begin
        state_next.literal_left = swm_pkg::LIT_IDLE;
        state_next.scan_mode    = swm_pkg::SCAN_NORMAL;
      end
    end else if (state_cur.scan_mode == swm_pkg::SCAN_DIRECTIVE) begin
      if (in_byte == swm_pkg::CH_LF) begin
        result.count              = 2'd1;
        state_next.last_emitted   = swm_pkg::CH_LF;
        state_next.pending_white  = 1'b1;
        state_next.line_started   = 1'b0;
        state_next.scan_mode      = swm_pkg::SCAN_NORMAL;
      end else begin
        state_next = lb_state;
        result     = lb_result;
      end
    end else if ((in_byte == swm_pkg::CH_DQUOTE) &&
                 (state_cur.last_emitted != swm_pkg::CH_BSLASH)) begin
      result.count            = 2'd1;
      state_next.scan_mode    = (state_cur.scan_mode == swm_pkg::SCAN_STRING) ?
                                swm_pkg::SCAN_NORMAL : swm_pkg::SCAN_STRING;
      state_next.last_emitted = in_byte;
    end else if (state_cur.scan_mode == swm_pkg::SCAN_STRING) begin
      result.count            = 2'd1;
      state_next.last_emitted = in_byte;
    end else if (in_byte == swm_pkg::CH_SQUOTE) begin
      result.count            = 2'd1;
      state_next.scan_mode    = swm_pkg::SCAN_LITERAL;
      state_next.literal_left = swm_pkg::LIT_FIRST;
    end else if ((in_byte == swm_pkg::CH_HASH) ||
                 ((in_byte == swm_pkg::CH_SLASH) &&
                  (state_cur.last_emitted == swm_pkg::CH_SLASH))) begin
      // directive or comment: a directive starts on a fresh line
      if ((in_byte == swm_pkg::CH_HASH) && (state_cur.last_emitted != swm_pkg::CH_LF)) begin
        result.count      = 2'd2;
        result.first_byte = swm_pkg::CH_LF;
      end else begin
        result.count = 2'd1;
      end
      state_next.scan_mode     = swm_pkg::SCAN_DIRECTIVE;
      state_next.line_started  = 1'b0;
      state_next.pending_white = 1'b0;
    end else if (swm_pkg::is_white(in_byte)) begin
      state_next.pending_white = 1'b1;
    end else begin
      if (state_cur.pending_white &&
          swm_pkg::space_needed(state_cur.last_emitted, in_byte)) begin
        result.count      = 2'd2;
        result.first_byte = swm_pkg::CH_SPACE;
      end else begin
        result.count = 2'd1;
      end
      state_next.pending_white = 1'b0;
      state_next.last_emitted  = in_byte;
    end
  end

endmodule

// ===== rtl/source_whitespace_minifier_top.sv =====
// Top level of the streaming whitespace minifier: input register, step logic, result queue.
// Path: the input register, then the four-entry result queue, lie between acceptance
//   and the first result byte valid on the master side.
// Throughput: one request per cycle while the queue has room for two bytes.
// Reset (rst, synchronous, active high): clears the scan state, empties the input
//   register and result queue, and returns newline_mode to line mode.
module source_whitespace_minifier_top (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tuser,   // [0] command
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast    // run_last
);

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } q_entry_t;

  logic                  newline_mode;

  // input register
  logic                  in_valid;
  logic                  in_command;
  logic [7:0]            in_byte;

  swm_pkg::swm_state_t   state;
  swm_pkg::swm_state_t   state_next;
  swm_pkg::swm_result_t  result;

  // result queue
  q_entry_t              queue [QDepth];
  logic [QPtrW-1:0]      head;
  logic [QPtrW-1:0]      tail;
  logic [QCntW-1:0]      count;
  logic [QCntW-1:0]      count_next;

  logic                  advance;
  logic                  pop;

  // Configuration: one register at addresses 0 to 3; writes elsewhere are dropped.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'd0, newline_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      newline_mode <= swm_pkg::MODE_LINE;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      newline_mode <= pwdata[0];
    end
  end

  // Advance the held request once the queue has room for two bytes; the room test
  // looks only at the current fill, so no path runs from m_axis_tready to s_axis_tready.
  assign advance       = in_valid && (count <= QCntW'(QDepth - 2));
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_command <= s_axis_tuser;
      in_byte    <= s_axis_tdata;
    end
  end

  swm_step u_step (
    .newline_mode (newline_mode),
    .command      (in_command),
    .in_byte      (in_byte),
    .state_cur    (state),
    .state_next   (state_next),
    .result       (result)
  );

  // Scan state moves only when a request is consumed.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swm_pkg::STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result queue: push up to two bytes per cycle, pop one.
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = (count != '0);
  assign m_axis_tdata  = queue[head].data;
  assign m_axis_tlast  = queue[head].last;

  always_comb begin
    count_next = count;
    if (advance) count_next = count_next + QCntW'(result.count);
    if (pop)     count_next = count_next - QCntW'(1);
  end

  always_ff @(posedge clk) begin
    if (advance && (result.count != 2'd0)) begin
      queue[tail] <= '{data: result.first_byte, last: (result.count == 2'd1)};
    end
    if (advance && (result.count == 2'd2)) begin
      queue[tail + QPtrW'(1)] <= '{data: result.second_byte, last: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (advance) tail <= tail + QPtrW'(result.count);
      if (pop)     head <= head + QPtrW'(1);
      count <= count_next;
    end
  end

endmodule

// ===== dv/swm_checker.sv =====
// Checker for the whitespace minifier: predicts the compacted bytes of each request and compares.
`timescale 1ns / 100ps
module swm_checker
  import swm_pkg::*;
#(
  parameter logic [2:0] MODE_ADDR = 3'd0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tuser,   // [0] command
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  input  logic        m_axis_tlast,   // run_last
  output int          fail_count,
  output int          outstanding
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_byte_t;

  text_byte_t minified_q[$];
  logic [7:0] step_bytes[$];

  logic       newline_mode = MODE_LINE;
  scan_mode_t scan         = SCAN_NORMAL;
  logic [1:0] lit_left     = LIT_IDLE;
  logic [7:0] last_byte    = CH_NUL;
  logic       gap_seen     = 1'b0;
  logic       line_open    = 1'b0;

  function automatic logic ws_char(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic punct_char(input logic [7:0] c);
    case (c)
      CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK,
      CH_LT, CH_GT, CH_PLUS, CH_MINUS, CH_SLASH, CH_STAR, CH_AMP, CH_CARET,
      CH_PCT, CH_SEMI, CH_COLON, CH_EQ, CH_COMMA, CH_NUL: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic eq_then_op(input logic [7:0] a, input logic [7:0] b);
    return (a == CH_EQ) && ((b == CH_PLUS) || (b == CH_MINUS) || (b == CH_STAR) ||
                            (b == CH_SLASH) || (b == CH_LT) || (b == CH_GT));
  endfunction

  function automatic logic wants_space(input logic [7:0] a, input logic [7:0] b);
    logic both_plain;
    both_plain = (a != CH_LF) && (b != CH_LF) && !punct_char(a) && !punct_char(b);
    return both_plain || eq_then_op(a, b) || eq_then_op(b, a);
  endfunction

  task automatic emit(input logic [7:0] b);
    if (step_bytes.size() < 2) step_bytes.push_back(b);
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t swm_checker: %s: got %02h, want %02h", $time, what, got, want);
    fail_count++;
  endtask

  // compaction within one line, shared by line mode and directive lines
  task automatic compact_in_line(input logic [7:0] c);
    if (ws_char(c)) begin
      if (line_open) gap_seen = 1'b1;
    end else begin
      if (line_open && gap_seen && wants_space(last_byte, c)) emit(CH_SPACE);
      line_open = 1'b1;
      gap_seen  = 1'b0;
      emit(c);
      last_byte = c;
    end
  endtask

  task automatic collapse_whole_file(input logic [7:0] c);
    if (scan == SCAN_LITERAL) begin
      emit(c);
      if (lit_left == LIT_FIRST) begin
        lit_left = (c == CH_BSLASH) ? LIT_ESCAPED : LIT_CLOSE;
      end else if (lit_left == LIT_ESCAPED) begin
        lit_left = LIT_CLOSE;
      end else begin
        lit_left = LIT_IDLE;
        scan     = SCAN_NORMAL;
      end
    end else if (scan == SCAN_DIRECTIVE) begin
      if (c == CH_LF) begin
        emit(CH_LF);
        last_byte = CH_LF;
        gap_seen  = 1'b1;
        line_open = 1'b0;
        scan      = SCAN_NORMAL;
      end else begin
        compact_in_line(c);
      end
    end else if ((c == CH_DQUOTE) && (last_byte != CH_BSLASH)) begin
      emit(c);
      scan      = (scan == SCAN_STRING) ? SCAN_NORMAL : SCAN_STRING;
      last_byte = c;
    end else if (scan == SCAN_STRING) begin
      emit(c);
      last_byte = c;
    end else if (c == CH_SQUOTE) begin
      emit(c);
      scan     = SCAN_LITERAL;
      lit_left = LIT_FIRST;
    end else if ((c == CH_HASH) || ((c == CH_SLASH) && (last_byte == CH_SLASH))) begin
      if ((c == CH_HASH) && (last_byte != CH_LF)) emit(CH_LF);
      emit(c);
      scan      = SCAN_DIRECTIVE;
      line_open = 1'b0;
      gap_seen  = 1'b0;
    end else if (ws_char(c)) begin
      gap_seen = 1'b1;
    end else begin
      if (gap_seen && wants_space(last_byte, c)) emit(CH_SPACE);
      gap_seen = 1'b0;
      emit(c);
      last_byte = c;
    end
  endtask

  task automatic minify_request(input logic cmd, input logic [7:0] c);
    text_byte_t entry;
    step_bytes.delete();
    if (cmd == CMD_END) begin
      if (newline_mode == MODE_LINE) begin
        if (line_open) emit(CH_LF);
      end else if (scan == SCAN_DIRECTIVE) begin
        emit(CH_LF);
      end
      scan      = SCAN_NORMAL;
      lit_left  = LIT_IDLE;
      last_byte = CH_NUL;
      gap_seen  = 1'b0;
      line_open = 1'b0;
    end else if (newline_mode == MODE_LINE) begin
      if (c == CH_LF) begin
        if (line_open) emit(CH_LF);
        line_open = 1'b0;
        gap_seen  = 1'b0;
      end else begin
        compact_in_line(c);
      end
    end else begin
      collapse_whole_file(c);
    end
    for (int i = 0; i < step_bytes.size(); i++) begin
      entry.data = step_bytes[i];
      entry.last = (i == step_bytes.size() - 1);
      minified_q.push_back(entry);
    end
  endtask

  always @(posedge clk) begin : track
    text_byte_t want;
    if (rst) begin
      minified_q.delete();
      newline_mode = MODE_LINE;
      scan         = SCAN_NORMAL;
      lit_left     = LIT_IDLE;
      last_byte    = CH_NUL;
      gap_seen     = 1'b0;
      line_open    = 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && (paddr == MODE_ADDR))
        newline_mode = pwdata[0];
      if (m_axis_tvalid && m_axis_tready) begin
        if (minified_q.size() == 0) begin
          report_mismatch("result byte with nothing expected", m_axis_tdata, 8'h00);
        end else begin
          want = minified_q.pop_front();
          if (m_axis_tdata !== want.data)
            report_mismatch("out_byte", m_axis_tdata, want.data);
          if (m_axis_tlast !== want.last)
            report_mismatch("run_last", {7'd0, m_axis_tlast}, {7'd0, want.last});
        end
      end
      if (s_axis_tvalid && s_axis_tready) minify_request(s_axis_tuser, s_axis_tdata);
    end
    outstanding <= minified_q.size();
  end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the whitespace minifier: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 100ps
module tb;
  import swm_pkg::*;

  localparam logic [2:0] MODE_REG_ADDR   = 3'd0;
  localparam int         TARGET_REQUESTS = 500;
  localparam int         RX_HOLD_CYCLES  = 160;
  localparam int         STALL_LIMIT     = 1000;
  localparam int         DRAIN_CYCLES    = 4;
  localparam int         TAIL_CYCLES     = 8;

  logic        clk;
  logic        rst           = 1'b1;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tuser  = CMD_DATA;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  int fail_count;
  int outstanding;
  int requests_sent = 0;
  bit jitter_on     = 1'b1;  // random idling on both sides
  bit rx_hold_req   = 1'b0;  // ask the receiver for one long hold-off

  string word_chars  = "abcdefxyz_QZ0159";
  string punct_chars = "(){}[]<>+-/*&^%;:=,";
  string op_chars    = "+-*/<>";

  source_whitespace_minifier_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  swm_checker #(.MODE_ADDR(MODE_REG_ADDR)) u_checker (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count    (fail_count),
    .outstanding   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Offer one request and hold it until the block takes it. Idle gaps come first,
  // with tvalid dropped, so a back-to-back request never lowers and raises tvalid
  // within one step.
  task automatic send_req(input logic cmd, input logic [7:0] b);
    while (jitter_on && ($urandom_range(99) < 22)) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    requests_sent++;
  endtask

  task automatic send_text(input string txt);
    for (int i = 0; i < txt.len(); i++) send_req(CMD_DATA, txt[i]);
  endtask

  function automatic logic [7:0] pick_from(input string chars);
    return chars[$urandom_range(chars.len() - 1)];
  endfunction

  // Mostly a plain space; otherwise one of the control whitespace bytes.
  function automatic logic [7:0] gap_char(input bit allow_newline);
    logic [7:0] ch;
    if ($urandom_range(2) != 0) return CH_SPACE;
    ch = CH_TAB + 8'($urandom_range(4));
    if (!allow_newline && (ch == CH_LF)) ch = CH_TAB;
    return ch;
  endfunction

  // Stop offering, wait until every predicted byte has come back, then allow the
  // pipeline to settle in case the last request produced nothing.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write newline_mode only once the block is idle; upper data bits are don't-care.
  task automatic set_mode(input logic mode);
    logic [31:0] wdata;
    wait_drained();
    wdata    = $urandom;
    wdata[0] = mode;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MODE_REG_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // One fragment of source-like text: mostly well-formed tokens, strings, literals,
  // directives and comments with random content, plus noise and cut-off constructs.
  task automatic send_fragment();
    int kind;
    int n;
    kind = $urandom_range(19);
    case (kind)
      0: begin
        send_req(CMD_END, 8'($urandom_range(255)));
      end
      1, 2, 3, 4, 19: begin
        n = $urandom_range(1, 6);
        repeat (n) send_req(CMD_DATA, pick_from(word_chars));
      end
      5, 6: begin
        send_req(CMD_DATA, pick_from(punct_chars));
      end
      7, 8, 9: begin
        n = $urandom_range(1, 3);
        repeat (n) send_req(CMD_DATA, gap_char(1'b1));
      end
      10: begin
        // '=' meeting an arithmetic or angle operator across a gap
        if ($urandom_range(1) != 0) begin
          send_req(CMD_DATA, CH_EQ);
          send_req(CMD_DATA, gap_char(1'b0));
          send_req(CMD_DATA, pick_from(op_chars));
        end else begin
          send_req(CMD_DATA, pick_from(op_chars));
          send_req(CMD_DATA, gap_char(1'b0));
          send_req(CMD_DATA, CH_EQ);
        end
      end
      11, 12: begin
        send_req(CMD_DATA, CH_DQUOTE);
        n = $urandom_range(0, 5);
        repeat (n) begin
          case ($urandom_range(3))
            0: send_req(CMD_DATA, pick_from(word_chars));
            1: send_req(CMD_DATA, gap_char(1'b0));
            2: begin
              send_req(CMD_DATA, CH_BSLASH);
              send_req(CMD_DATA, CH_DQUOTE);
            end
            default: send_req(CMD_DATA, 8'($urandom_range(8'h20, 8'h7E)));
          endcase
        end
        // occasionally cut the string off with the end of the stream
        if ($urandom_range(7) == 0) send_req(CMD_END, 8'($urandom_range(255)));
        else send_req(CMD_DATA, CH_DQUOTE);
      end
      13: begin
        send_req(CMD_DATA, CH_SQUOTE);
        if ($urandom_range(3) == 0) send_req(CMD_DATA, CH_BSLASH);
        if ($urandom_range(5) == 0) begin
          send_req(CMD_END, 8'($urandom_range(255)));
        end else begin
          send_req(CMD_DATA, 8'($urandom_range(255)));
          if ($urandom_range(4) == 0) send_req(CMD_DATA, 8'($urandom_range(255)));
          else send_req(CMD_DATA, CH_SQUOTE);
        end
      end
      14, 15: begin
        // directive or comment line; tokens split by optional non-newline whitespace
        if (kind == 14) begin
          send_req(CMD_DATA, CH_HASH);
        end else begin
          send_req(CMD_DATA, CH_SLASH);
          n = $urandom_range(0, 2);
          repeat (n) send_req(CMD_DATA, gap_char(1'b0));
          send_req(CMD_DATA, CH_SLASH);
        end
        n = $urandom_range(1, 4);
        repeat (n) begin
          repeat ($urandom_range(0, 2)) send_req(CMD_DATA, gap_char(1'b0));
          if ($urandom_range(2) == 0) send_req(CMD_DATA, pick_from(punct_chars));
          else send_req(CMD_DATA, pick_from(word_chars));
        end
        if ($urandom_range(5) == 0) send_req(CMD_END, 8'($urandom_range(255)));
        else send_req(CMD_DATA, CH_LF);
      end
      16: begin
        n = $urandom_range(1, 3);
        repeat (n) send_req(CMD_DATA, 8'($urandom_range(255)));
      end
      default: begin
        // newlines, with the odd blank or whitespace-only line
        n = $urandom_range(1, 2);
        repeat (n) begin
          if ($urandom_range(2) == 0) send_req(CMD_DATA, gap_char(1'b0));
          send_req(CMD_DATA, CH_LF);
        end
      end
    endcase
  endtask

  // Receiver: random back-pressure, one long hold-off on request, none while calm.
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end else begin
        m_axis_tready <= !jitter_on || ($urandom_range(99) >= 22);
      end
    end
  end

  // Watchdog: end the run if nothing moves on either stream for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("tb: FAIL");
    $finish;
  end

  initial begin : stimulus
    int phase;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Line mode from reset: leading tab trimmed, inner gap cut to one space, blank line dropped,
    // the byte extremes, and the closing newline on end of stream.
    send_text("\ta  b\n\n");
    send_req(CMD_DATA, 8'hFF);
    send_req(CMD_DATA, CH_NUL);
    send_req(CMD_END, 8'h00);

    // Whole-file mode: leading space, space before a quote, escaped quote inside a
    // string, character literal, comment start split by a space, directive after
    // a newline, and end of stream inside the directive.
    set_mode(MODE_WHOLE);
    send_text(" x \"\\\" b\" 'q'/ /c\n#e");
    send_req(CMD_END, 8'hFF);

    // Random phases. Phases do not always end the stream, so a mode change often
    // lands mid-stream and the new mode picks up the old state.
    phase = 0;
    while (requests_sent < TARGET_REQUESTS) begin
      if (phase < 4) set_mode(phase[0] ? MODE_WHOLE : MODE_LINE);
      else set_mode(1'($urandom_range(1)));
      jitter_on = (phase != 2);
      // keep offering while the receiver holds off, so the block backs up
      if (phase == 3) rx_hold_req = 1'b1;
      repeat ($urandom_range(25, 40)) send_fragment();
      phase++;
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if ((fail_count == 0) && (outstanding == 0)) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/swm_pkg.sv
rtl/swm_step.sv
rtl/source_whitespace_minifier_top.sv
dv/swm_checker.sv
dv/tb.sv
